/* design/prl_pkg.sv */
// ----------------------------------------------------------------------------
// prl_pkg
// Shared types and codes for the positional record list.
// ----------------------------------------------------------------------------
package prl_pkg;

   // operation codes (req_tuser)
   localparam logic [2:0] OP_INSERT      = 3'd0;
   localparam logic [2:0] OP_DELETE      = 3'd1;
   localparam logic [2:0] OP_SRCH_FIRST  = 3'd2;
   localparam logic [2:0] OP_SRCH_SECOND = 3'd3;
   localparam logic [2:0] OP_DUMP        = 3'd4;

   // status codes (rsp_tuser)
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_BADPOS = 2'd2;
   localparam logic [1:0] ST_NONE   = 2'd3;

   localparam int KEY_W    = 64;
   localparam int POS_W    = 5;
   localparam int OP_W     = 3;
   localparam int STAT_W   = 2;
   localparam int CNT_W    = 6;
   localparam int REQ_W    = 264;
   localparam int RSP_W    = 208;
   localparam int RESULT_CAP = 32;

   // one stored entry, first key in the low bits
   typedef struct packed {
      logic [KEY_W-1:0] word;
      logic [KEY_W-1:0] second;
      logic [KEY_W-1:0] first;
   } record_type;

   localparam int REC_W = $bits(record_type);

endpackage

/* design/prl_ram.sv */
// ----------------------------------------------------------------------------
// prl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module prl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/positional_record_list_top.sv */
// ----------------------------------------------------------------------------
// positional_record_list_top
// Ordered list of up to DEPTH records with positional insert/delete,
// search by either key and full dump.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one item per operation. tuser = operation code, tdata
//    carries position, the record to insert and the search key.
//  - rsp channel: insert, delete and bad codes give one item. Search and
//    dump give one item per reported entry (at most 32), tlast on the
//    final one; no match or an empty list gives one "no entry" item.
//  - All entries sit in one RAM (192 bits per entry, registered read).
//    Insert/delete move the tail one entry per cycle: read an entry,
//    write it one slot up or down the next cycle. Insert then writes
//    the new record; a finish state loads the output register and the
//    idle state takes the next item. A search or dump reads one entry
//    per cycle from the RAM read port, except while stalled (see below).
//  - One item is worked at a time; req_tready is high only when idle.
//    A finished result waits in the output register while the next item
//    is taken.
//  - rsp_tready low stalls a search or dump once a second hit is found;
//    the scan resumes when the output register frees up. Nothing is dropped.
//  - Reset empties the list at once; stored data is left as is.
// ----------------------------------------------------------------------------
module positional_record_list_top #(
   parameter int DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [4:0] position, [68:5] first_key, [132:69] second_key,
   // [196:133] record_word, [260:197] search_key, [263:261] zero
   input  logic [prl_pkg::REQ_W-1:0]         req_tdata,
   // [2:0] operation
   input  logic [prl_pkg::OP_W-1:0]          req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [4:0] entry_index, [68:5] out_first, [132:69] out_second,
   // [196:133] out_word, [202:197] entries_now, [207:203] zero
   output logic [prl_pkg::RSP_W-1:0]         rsp_tdata,
   // [1:0] status
   output logic [prl_pkg::STAT_W-1:0]        rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > prl_pkg::POS_W) ? CW : prl_pkg::POS_W;
   localparam int CAP = prl_pkg::RESULT_CAP;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INS  = 3'd1;
   localparam logic [2:0] S_DEL  = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   // control state
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] left_ff, left_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] raddr_ff, raddr_in;
   logic          rv_ff, rv_in;
   logic          pend_v_ff, pend_v_in;
   logic [prl_pkg::CNT_W-1:0] n_ff, n_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // item payload
   logic [prl_pkg::OP_W-1:0]   op_ff, op_in;
   logic [prl_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [prl_pkg::KEY_W-1:0]  key_ff, key_in;
   prl_pkg::record_type        rec_ff, rec_in;
   logic [prl_pkg::STAT_W-1:0] status_ff, status_in;

   // held hit, sent once the next hit or the scan end is known
   logic [prl_pkg::POS_W-1:0]  pend_idx_ff, pend_idx_in;
   prl_pkg::record_type        pend_rec_ff, pend_rec_in;

   // output register
   logic [prl_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [prl_pkg::POS_W-1:0]  rsp_idx_ff, rsp_idx_in;
   prl_pkg::record_type        rsp_rec_ff, rsp_rec_in;
   logic [prl_pkg::CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic                       rsp_last_ff, rsp_last_in;

   // RAM port
   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_wa, ram_ra;
   prl_pkg::record_type ram_wd, ram_rd;

   logic          out_free, hit, take, stall, issue;
   logic [XW-1:0] pos_x, tot_x;

   prl_ram #(
      .WIDTH (prl_pkg::REC_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pos_x    = XW'(req_tdata[prl_pkg::POS_W-1:0]);
   assign tot_x    = XW'(total_ff);

   always_comb begin
      case (op_ff)
         prl_pkg::OP_SRCH_FIRST:  hit = (ram_rd.first == key_ff);
         prl_pkg::OP_SRCH_SECOND: hit = (ram_rd.second == key_ff);
         default:                 hit = 1'b1;
      endcase
   end

   // a hit counts only below the result cap
   assign take  = rv_ff && hit && (n_ff != prl_pkg::CNT_W'(CAP));
   // second hit with the previous one still parked and no room out
   assign stall = (state_ff == S_SCAN) && take && pend_v_ff && !out_free;
   assign issue = !stall && (left_ff != '0) && (n_ff != prl_pkg::CNT_W'(CAP));

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      left_in     = left_ff;
      ptr_in      = ptr_ff;
      raddr_in    = raddr_ff;
      rv_in       = 1'b0;
      pend_v_in   = pend_v_ff;
      n_in        = n_ff;
      op_in       = op_ff;
      pos_in      = pos_ff;
      key_in      = key_ff;
      rec_in      = rec_ff;
      status_in   = status_ff;
      pend_idx_in = pend_idx_ff;
      pend_rec_in = pend_rec_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;

      ram_we = 1'b0;
      ram_wa = raddr_ff;
      ram_wd = ram_rd;
      ram_re = 1'b0;
      ram_ra = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_tuser;
               pos_in = req_tdata[prl_pkg::POS_W-1:0];
               rec_in = prl_pkg::record_type'(req_tdata[prl_pkg::REC_W+4:5]);
               key_in = req_tdata[prl_pkg::REQ_W-4:prl_pkg::REC_W+5];
               unique case (req_tuser) inside
                  prl_pkg::OP_INSERT: begin
                     if (tot_x >= XW'(DEPTH)) begin
                        status_in = prl_pkg::ST_FULL;
                        state_in  = S_FIN;
                     end else if (pos_x > tot_x) begin
                        status_in = prl_pkg::ST_BADPOS;
                        state_in  = S_FIN;
                     end else begin
                        status_in = prl_pkg::ST_OK;
                        ptr_in    = AW'(tot_x - XW'(1));
                        left_in   = CW'(tot_x - pos_x);
                        state_in  = S_INS;
                     end
                  end
                  prl_pkg::OP_DELETE: begin
                     if (pos_x >= tot_x) begin
                        status_in = prl_pkg::ST_BADPOS;
                        state_in  = S_FIN;
                     end else begin
                        status_in = prl_pkg::ST_OK;
                        ptr_in    = AW'(pos_x + XW'(1));
                        left_in   = CW'(tot_x - pos_x - XW'(1));
                        state_in  = S_DEL;
                     end
                  end
                  prl_pkg::OP_SRCH_FIRST, prl_pkg::OP_SRCH_SECOND,
                  prl_pkg::OP_DUMP: begin
                     status_in = prl_pkg::ST_NONE;
                     ptr_in    = '0;
                     left_in   = total_ff;
                     n_in      = '0;
                     state_in  = S_SCAN;
                  end
                  default: begin
                     status_in = prl_pkg::ST_BADPOS;
                     state_in  = S_FIN;
                  end
               endcase
            end
         end

         S_INS: begin
            // walk down from the top, each entry moves one slot up
            if (left_ff != '0) begin
               ram_re   = 1'b1;
               ptr_in   = ptr_ff - AW'(1);
               left_in  = left_ff - CW'(1);
               raddr_in = ptr_ff;
               rv_in    = 1'b1;
            end
            if (rv_ff) begin
               ram_we = 1'b1;
               ram_wa = raddr_ff + AW'(1);
            end
            if ((left_ff == '0) && !rv_ff) begin
               ram_we   = 1'b1;
               ram_wa   = AW'(pos_ff);
               ram_wd   = rec_ff;
               total_in = total_ff + CW'(1);
               state_in = S_FIN;
            end
         end

         S_DEL: begin
            // walk up from the hole, each entry moves one slot down
            if (left_ff != '0) begin
               ram_re   = 1'b1;
               ptr_in   = ptr_ff + AW'(1);
               left_in  = left_ff - CW'(1);
               raddr_in = ptr_ff;
               rv_in    = 1'b1;
            end
            if (rv_ff) begin
               ram_we = 1'b1;
               ram_wa = raddr_ff - AW'(1);
            end
            if ((left_ff == '0) && !rv_ff) begin
               total_in = total_ff - CW'(1);
               state_in = S_FIN;
            end
         end

         S_SCAN: begin
            if (issue) begin
               ram_re   = 1'b1;
               ptr_in   = ptr_ff + AW'(1);
               left_in  = left_ff - CW'(1);
               raddr_in = ptr_ff;
               rv_in    = 1'b1;
            end else if (stall) begin
               rv_in = 1'b1;
            end
            if (take && !stall) begin
               if (pend_v_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = prl_pkg::ST_OK;
                  rsp_idx_in    = pend_idx_ff;
                  rsp_rec_in    = pend_rec_ff;
                  rsp_cnt_in    = prl_pkg::CNT_W'(total_ff);
                  rsp_last_in   = 1'b0;
               end
               pend_v_in   = 1'b1;
               pend_idx_in = prl_pkg::POS_W'(raddr_ff);
               pend_rec_in = ram_rd;
               n_in        = n_ff + prl_pkg::CNT_W'(1);
            end
            if (!rv_ff && ((left_ff == '0) || (n_ff == prl_pkg::CNT_W'(CAP)))) begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cnt_in   = prl_pkg::CNT_W'(total_ff);
               rsp_last_in  = 1'b1;
               if (pend_v_ff) begin
                  rsp_status_in = prl_pkg::ST_OK;
                  rsp_idx_in    = pend_idx_ff;
                  rsp_rec_in    = pend_rec_ff;
               end else begin
                  rsp_status_in = status_ff;
                  rsp_idx_in    = '0;
                  rsp_rec_in    = '0;
               end
               pend_v_in = 1'b0;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         left_ff      <= '0;
         ptr_ff       <= '0;
         raddr_ff     <= '0;
         rv_ff        <= 1'b0;
         pend_v_ff    <= 1'b0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         left_ff      <= left_in;
         ptr_ff       <= ptr_in;
         raddr_ff     <= raddr_in;
         rv_ff        <= rv_in;
         pend_v_ff    <= pend_v_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      rec_ff        <= rec_in;
      status_ff     <= status_in;
      pend_idx_ff   <= pend_idx_in;
      pend_rec_ff   <= pend_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_cnt_ff, rsp_rec_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
